// File: design/fold_ruling_angles_unit_assert.svh
// assertion macros for the fold ruling angles unit
`ifndef FOLD_RULING_ANGLES_UNIT_ASSERT_SVH
`define FOLD_RULING_ANGLES_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define FRA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define FRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/frua_pkg.sv
// types, constants and tables shared by the fold ruling angles unit
`timescale 1ns / 1ps

package frua_pkg;

  localparam int DIV_STEPS    = 33;
  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 32;
  localparam int RDIV_STEPS   = 17;
  localparam int SIDE_LAT     = DIV_STEPS + 2 + SQRT_STEPS + RDIV_STEPS;
  localparam int ANG_DLY      = SIDE_LAT - (DIV_STEPS + CORDIC_STEPS + 2);
  localparam int COT_DLY      = SIDE_LAT - (DIV_STEPS + 1);

  localparam logic [17:0] HALF_PI_Q16 = 18'd102944;
  localparam logic [17:0] PI_Q16      = 18'd205887;
  localparam logic [27:0] HALF_PI_Q24 = 28'd26353589;
  localparam logic [31:0] DEGEN_COT   = 32'd655360000;
  localparam logic [16:0] ONE_Q16     = 17'd65536;

  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_RECT   = 2'd1,
    ST_DEGEN  = 2'd2
  } status_t;

  typedef struct packed {
    logic [32:0] nmag;
    logic        neg;
    logic [49:0] dmag;
  } side_in_t;

  typedef struct packed {
    logic signed [31:0] cot;
    logic [17:0]        angle;
    logic [16:0]        sine;
    logic signed [17:0] cosine;
  } side_out_t;

  // atan(2^-i) in units of 2^-24 rad
  function automatic logic signed [26:0] cordic_angle(input int i);
    logic signed [26:0] t;
    case (i)
      0: t = 27'sd13176795;
      1: t = 27'sd7778716;
      2: t = 27'sd4110060;
      3: t = 27'sd2086331;
      4: t = 27'sd1047214;
      5: t = 27'sd524117;
      6: t = 27'sd262123;
      7: t = 27'sd131069;
      default: t = 27'sd1 <<< (24 - i);
    endcase
    return t;
  endfunction

endpackage

// File: design/fold_ruling_angles_unit.sv
// top level of the fold ruling angles unit
`timescale 1ns / 1ps
`include "fold_ruling_angles_unit_assert.svh"

// Streams one curve point per word and returns the left and right ruling cotangents,
// angles, sines and cosines of that point. One point is taken in every cycle unless
// the output stalls; the latency is set by the 33-step cotangent divider, the 32-step
// square root and the 17-step reciprocal dividers, one step per pipeline stage, for
// each side. A stall on the output freezes the whole pipeline. The rectify registers
// are written through the apb port at byte addresses 0 (enable) and 4 (threshold).
module fold_ruling_angles_unit import frua_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // alpha_rate, torsion, sin_alpha, curvature, plane_curvature
  input  logic [151:0] s_tdata,
  // mirror
  input  logic         s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // cot_left, cot_right, angle_left, angle_right, sine_left, sine_right,
  // cosine_left, cosine_right
  output logic [175:0] m_tdata,
  // status
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);

  logic        rect_en;
  logic [30:0] rect_thr;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESH) ? {1'b0, rect_thr} : {31'd0, rect_en};

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_en  <= 1'b0;
      rect_thr <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_ENABLE) begin
        rect_en <= pwdata[0];
      end else begin
        rect_thr <= pwdata[30:0];
      end
    end
  end

  logic en;
  logic out_valid;

  assign en       = !out_valid || m_tready;
  assign s_tready = en;

  // input decode
  logic signed [31:0] a_in, t_in, k_in, p_in;
  logic signed [17:0] s_in;
  logic [31:0]        pmag, kmag;
  logic [17:0]        smag;
  logic signed [32:0] nl, nr;
  logic               dsgn;
  status_t            st_next;
  side_in_t           left_in, right_in;

  assign a_in = $signed(s_tdata[31:0]);
  assign t_in = $signed(s_tdata[63:32]);
  assign s_in = $signed(s_tdata[81:64]);
  assign k_in = $signed(s_tdata[113:82]);
  assign p_in = $signed(s_tdata[145:114]);

  always_comb begin
    pmag = p_in[31] ? 32'(-p_in) : 32'(p_in);
    kmag = k_in[31] ? 32'(-k_in) : 32'(k_in);
    smag = s_in[17] ? 18'(-s_in) : 18'(s_in);
    dsgn = s_in[17] ^ k_in[31];
    if (s_tuser) begin
      nl = 33'(t_in) - 33'(a_in);
      nr = 33'(t_in) + 33'(a_in);
    end else begin
      nl = 33'(t_in) + 33'(a_in);
      nr = 33'(t_in) - 33'(a_in);
    end
    if (rect_en && (pmag < {1'b0, rect_thr})) begin
      st_next = ST_RECT;
    end else if (s_in == 18'sd0 || k_in == 32'sd0) begin
      st_next = ST_DEGEN;
    end else begin
      st_next = ST_NORMAL;
    end
    left_in.dmag  = 50'(smag) * 50'(kmag);
    right_in.dmag = left_in.dmag;
    left_in.nmag  = nl[32] ? 33'(-nl) : 33'(nl);
    right_in.nmag = nr[32] ? 33'(-nr) : 33'(nr);
    left_in.neg   = nl[32] ^ dsgn;
    right_in.neg  = nr[32] ^ dsgn;
  end

  side_out_t left_out, right_out;

  frua_side u_left (
    .clk  (clk),
    .en   (en),
    .din  (left_in),
    .dout (left_out)
  );

  frua_side u_right (
    .clk  (clk),
    .en   (en),
    .din  (right_in),
    .dout (right_out)
  );

  // valid, status and last travel with the side pipelines
  logic    v_d   [0:SIDE_LAT];
  status_t st_d  [0:SIDE_LAT];
  logic    lst_d [0:SIDE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d[0] <= 1'b0;
    end else if (en) begin
      v_d[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_d[0]  <= st_next;
      lst_d[0] <= s_tlast;
    end
  end

  for (genvar k = 0; k < SIDE_LAT; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        v_d[k+1] <= 1'b0;
      end else if (en) begin
        v_d[k+1] <= v_d[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_d[k+1]  <= st_d[k];
        lst_d[k+1] <= lst_d[k];
      end
    end
  end

  // output word
  side_out_t left_fin, right_fin;

  always_comb begin
    case (st_d[SIDE_LAT])
      ST_RECT: begin
        left_fin = '{cot: '0, angle: HALF_PI_Q16, sine: '0, cosine: '0};
      end
      ST_DEGEN: begin
        left_fin = '{cot: DEGEN_COT, angle: HALF_PI_Q16, sine: ONE_Q16, cosine: '0};
      end
      default: begin
        left_fin = left_out;
      end
    endcase
    right_fin = (st_d[SIDE_LAT] == ST_NORMAL) ? right_out : left_fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_d[SIDE_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {6'd0, right_fin.cosine, left_fin.cosine, right_fin.sine, left_fin.sine,
                  right_fin.angle, left_fin.angle, right_fin.cot, left_fin.cot};
      m_tuser <= st_d[SIDE_LAT];
      m_tlast <= lst_d[SIDE_LAT];
    end
  end

  assign m_tvalid = out_valid;

  `FRA_ASSERT_IMP(a_rect_flat, m_tvalid && m_tuser == ST_RECT, m_tdata[63:0] == 64'd0 && m_tdata[169:100] == 70'd0, "rectified word not flat")
  `FRA_ASSERT_IMP(a_degen_sine, m_tvalid && m_tuser == ST_DEGEN, m_tdata[116:100] == ONE_Q16 && m_tdata[133:117] == ONE_Q16, "degenerate sine wrong")
  `FRA_ASSERT_IMP(a_angle_range, m_tvalid, m_tdata[81:64] <= PI_Q16 && m_tdata[99:82] <= PI_Q16, "angle beyond pi")

endmodule

// File: design/frua_side.sv
// one side: cotangent divider, cordic arctangent, root and reciprocal dividers
`timescale 1ns / 1ps

module frua_side import frua_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  side_in_t  din,
  output side_out_t dout
);

  // restoring divider for the cotangent
  logic [50:0]           r_d    [0:DIV_STEPS];
  logic [DIV_STEPS-1:0]  q_d    [0:DIV_STEPS];
  logic [49:0]           dm_d   [0:DIV_STEPS];
  logic                  neg_d  [0:DIV_STEPS];
  logic                  sat_d  [0:DIV_STEPS];
  logic                  zero_d [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      r_d[0]    <= 51'(din.nmag);
      q_d[0]    <= '0;
      dm_d[0]   <= din.dmag;
      neg_d[0]  <= din.neg;
      sat_d[0]  <= {17'd0, din.nmag, 1'b0} >= {1'b0, din.dmag};
      zero_d[0] <= din.nmag == 33'd0;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [50:0] sh;
    assign sh = {r_d[i][49:0], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        if (sh >= {1'b0, dm_d[i]}) begin
          r_d[i+1] <= sh - {1'b0, dm_d[i]};
          q_d[i+1] <= {q_d[i][DIV_STEPS-2:0], 1'b1};
        end else begin
          r_d[i+1] <= sh;
          q_d[i+1] <= {q_d[i][DIV_STEPS-2:0], 1'b0};
        end
        dm_d[i+1]   <= dm_d[i];
        neg_d[i+1]  <= neg_d[i];
        sat_d[i+1]  <= sat_d[i];
        zero_d[i+1] <= zero_d[i];
      end
    end
  end

  // rounding and saturation
  logic [33:0]        qp;
  logic [32:0]        mag;
  logic signed [31:0] cot_next;
  logic [31:0]        cmag_next;
  logic signed [31:0] cot_d [0:COT_DLY];
  logic [31:0]        cmag_c;

  assign qp  = {1'b0, q_d[DIV_STEPS]} + 34'd1;
  assign mag = qp[33:1];

  always_comb begin
    if (zero_d[DIV_STEPS]) begin
      cot_next = '0;
    end else if (sat_d[DIV_STEPS]) begin
      cot_next = neg_d[DIV_STEPS] ? 32'sh80000000 : 32'sh7fffffff;
    end else if (neg_d[DIV_STEPS]) begin
      cot_next = -$signed(mag[31:0]);
    end else if (mag > 33'h07fffffff) begin
      cot_next = 32'sh7fffffff;
    end else begin
      cot_next = $signed(mag[31:0]);
    end
    cmag_next = cot_next[31] ? 32'(-cot_next) : 32'(cot_next);
  end

  // cordic vectoring
  logic signed [55:0] x_d [0:CORDIC_STEPS];
  logic signed [55:0] y_d [0:CORDIC_STEPS];
  logic signed [26:0] z_d [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      cot_d[0] <= cot_next;
      cmag_c   <= cmag_next;
      x_d[0]   <= 56'sd1 <<< 36;
      y_d[0]   <= {{4{cot_next[31]}}, cot_next, 20'd0};
      z_d[0]   <= '0;
    end
  end

  for (genvar k = 0; k < COT_DLY; k++) begin : g_cot_dly
    always_ff @(posedge clk) begin
      if (en) begin
        cot_d[k+1] <= cot_d[k];
      end
    end
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    localparam logic signed [26:0] T = cordic_angle(j);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_d[j][55]) begin
          x_d[j+1] <= x_d[j] + (y_d[j] >>> j);
          y_d[j+1] <= y_d[j] - (x_d[j] >>> j);
          z_d[j+1] <= z_d[j] + T;
        end else begin
          x_d[j+1] <= x_d[j] - (y_d[j] >>> j);
          y_d[j+1] <= y_d[j] + (x_d[j] >>> j);
          z_d[j+1] <= z_d[j] - T;
        end
      end
    end
  end

  // angle = pi/2 - atan, rounded to q2.16 and clamped to 0..pi
  logic signed [27:0] beta;
  logic [27:0]        beta_pos;
  logic [19:0]        beta_rnd;
  logic [17:0]        ang_d [0:ANG_DLY];

  assign beta     = $signed(HALF_PI_Q24) - 28'(z_d[CORDIC_STEPS]);
  assign beta_pos = beta[27] ? 28'd0 : 28'(beta);
  assign beta_rnd = 20'((beta_pos + 28'd128) >> 8);

  always_ff @(posedge clk) begin
    if (en) begin
      ang_d[0] <= (beta_rnd > 20'(PI_Q16)) ? PI_Q16 : beta_rnd[17:0];
    end
  end

  for (genvar k = 0; k < ANG_DLY; k++) begin : g_ang_dly
    always_ff @(posedge clk) begin
      if (en) begin
        ang_d[k+1] <= ang_d[k];
      end
    end
  end

  // integer square root of 2^32 + c^2
  logic [63:0] v_d   [0:SQRT_STEPS];
  logic [63:0] res_d [0:SQRT_STEPS];
  logic [31:0] cm_d  [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      v_d[0]   <= (64'd1 << 32) + 64'(cmag_c) * 64'(cmag_c);
      res_d[0] <= '0;
      cm_d[0]  <= cmag_c;
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [63:0] B = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    assign trial = res_d[i] + B;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_d[i] >= trial) begin
          v_d[i+1]   <= v_d[i] - trial;
          res_d[i+1] <= (res_d[i] >> 1) + B;
        end else begin
          v_d[i+1]   <= v_d[i];
          res_d[i+1] <= res_d[i] >> 1;
        end
        cm_d[i+1] <= cm_d[i];
      end
    end
  end

  // rounded reciprocal dividers for sine and cosine
  logic [48:0] rs_d [0:RDIV_STEPS-1];
  logic [48:0] rc_d [0:RDIV_STEPS-1];
  logic [16:0] qs_d [0:RDIV_STEPS-1];
  logic [16:0] qc_d [0:RDIV_STEPS-1];
  logic [31:0] rr_d [0:RDIV_STEPS-1];

  for (genvar j = 0; j < RDIV_STEPS; j++) begin : g_rdiv
    logic [48:0] rs_in;
    logic [48:0] rc_in;
    logic [16:0] qs_in;
    logic [16:0] qc_in;
    logic [31:0] rr_in;
    logic [48:0] dv;
    if (j == 0) begin : g_first
      assign rr_in = res_d[SQRT_STEPS][31:0];
      assign rs_in = (49'd1 << 32) + 49'(rr_in >> 1);
      assign rc_in = {1'b0, cm_d[SQRT_STEPS], 16'd0} + 49'(rr_in >> 1);
      assign qs_in = '0;
      assign qc_in = '0;
    end else begin : g_rest
      assign rr_in = rr_d[j-1];
      assign rs_in = rs_d[j-1];
      assign rc_in = rc_d[j-1];
      assign qs_in = qs_d[j-1];
      assign qc_in = qc_d[j-1];
    end
    assign dv = 49'(rr_in) << (RDIV_STEPS - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        rr_d[j] <= rr_in;
        if (rs_in >= dv) begin
          rs_d[j] <= rs_in - dv;
          qs_d[j] <= {qs_in[15:0], 1'b1};
        end else begin
          rs_d[j] <= rs_in;
          qs_d[j] <= {qs_in[15:0], 1'b0};
        end
        if (rc_in >= dv) begin
          rc_d[j] <= rc_in - dv;
          qc_d[j] <= {qc_in[15:0], 1'b1};
        end else begin
          rc_d[j] <= rc_in;
          qc_d[j] <= {qc_in[15:0], 1'b0};
        end
      end
    end
  end

  assign dout.cot    = cot_d[COT_DLY];
  assign dout.angle  = ang_d[ANG_DLY];
  assign dout.sine   = qs_d[RDIV_STEPS-1];
  assign dout.cosine = cot_d[COT_DLY][31] ? -$signed({1'b0, qc_d[RDIV_STEPS-1]})
                                          : $signed({1'b0, qc_d[RDIV_STEPS-1]});

endmodule
